// ===== hdl/multi_slot_timer_bank_defines.svh =====
// Assertion macros for the timer slot bank.
`ifndef MULTI_SLOT_TIMER_BANK_DEFINES_SVH
`define MULTI_SLOT_TIMER_BANK_DEFINES_SVH

`ifndef SYNTHESIS
`define MSTB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MSTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MSTB_ASSERT_SAME(label, clk, rst, ante, cons)
`define MSTB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/mstb_pkg.sv =====
// Types and constants shared by the timer slot bank.
package mstb_pkg;

   localparam int REQ_W     = 3;
   localparam int SLOT_W    = 5;
   localparam int PERIOD_W  = 32;
   localparam int ELAPSED_W = 16;
   localparam int KIND_W    = 3;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD    = 3'd0,
      REQ_REMOVE = 3'd1,
      REQ_START  = 3'd2,
      REQ_STOP   = 3'd3,
      REQ_RESET  = 3'd4,
      REQ_TICK   = 3'd5
   } req_code_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED  = 3'd0,
      KIND_FULL   = 3'd1,
      KIND_ACK    = 3'd2,
      KIND_EXPIRY = 3'd3,
      KIND_DONE   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SIMPLE,
      ST_TICK_FIRST,
      ST_TICK_EVAL,
      ST_TICK_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic idx_clear;
      logic idx_inc;
      logic rd_en;
      logic do_add;
      logic do_full;
      logic do_simple;
      logic do_tick;
      logic do_done;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic idx_last;
      logic cur_free;
      logic expiring;
   } dp_status_type;

endpackage

// ===== hdl/mstb_if.sv =====
// Request and response channel interfaces of the timer slot bank.
interface mstb_req_if;
   import mstb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic [SLOT_W-1:0]    slot;
   logic [PERIOD_W-1:0]  period_ms;
   logic                 periodic;
   logic [ELAPSED_W-1:0] elapsed_ms;

   modport source (output valid, req_type, slot, period_ms, periodic, elapsed_ms,
                   input ready);
   modport sink (input valid, req_type, slot, period_ms, periodic, elapsed_ms,
                 output ready);
endinterface

interface mstb_rsp_if;
   import mstb_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SLOT_W-1:0] slot_out;
   logic              last;

   modport source (output valid, kind, slot_out, last, input ready);
   modport sink (input valid, kind, slot_out, last, output ready);
endinterface

// ===== hdl/mstb_ctrl.sv =====
// Sequencer of the timer slot bank: request decode, slot walk and result timing.
module mstb_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [mstb_pkg::REQ_W-1:0]  req_type,
   output logic                        req_ready,
   input  mstb_pkg::dp_status_type     status,
   output mstb_pkg::ctl_cmd_type       cmd
);
   import mstb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               unique case (req_type)
                  REQ_ADD: begin
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_ADD;
                  end
                  REQ_TICK: begin
                     state_in = ST_TICK_FIRST;
                  end
                  default: begin
                     state_in = ST_SIMPLE;
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (status.cur_free) begin
               if (status.out_free) begin
                  cmd.do_add = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if (status.idx_last) begin
               if (status.out_free) begin
                  cmd.do_full = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SIMPLE: begin
            if (status.out_free) begin
               cmd.do_simple = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_TICK_FIRST: begin
            cmd.idx_clear = 1'b1;
            cmd.rd_en     = 1'b1;
            state_in      = ST_TICK_EVAL;
         end
         ST_TICK_EVAL: begin
            if (!status.expiring || status.out_free) begin
               cmd.do_tick = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_TICK_DONE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         ST_TICK_DONE: begin
            if (status.out_free) begin
               cmd.do_done = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/mstb_datapath.sv =====
// Slot storage, tick arithmetic and response register of the timer slot bank.
module mstb_datapath #(
   parameter int SLOTS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mstb_pkg::ctl_cmd_type           cmd,
   output mstb_pkg::dp_status_type         status,
   input  logic [mstb_pkg::REQ_W-1:0]      req_type,
   input  logic [mstb_pkg::SLOT_W-1:0]     req_slot,
   input  logic [mstb_pkg::PERIOD_W-1:0]   req_period_ms,
   input  logic                            req_periodic,
   input  logic [mstb_pkg::ELAPSED_W-1:0]  req_elapsed_ms,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [mstb_pkg::KIND_W-1:0]     rsp_kind,
   output logic [mstb_pkg::SLOT_W-1:0]     rsp_slot_out,
   output logic                            rsp_last
);
   import mstb_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [REQ_W-1:0]     type_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [PERIOD_W-1:0]  period_ff;
   logic                 periodic_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [SLOTS-1:0] used_ff;
   logic [SLOTS-1:0] used_in;
   logic [SLOTS-1:0] running_ff;
   logic [SLOTS-1:0] running_in;

   logic [PERIOD_W:0]   cfg_mem [SLOTS];
   logic [PERIOD_W-1:0] rem_mem [SLOTS];
   logic [PERIOD_W:0]   cfg_rd_ff;
   logic [PERIOD_W-1:0] rem_rd_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   kind_type            kind_ff;
   logic [SLOT_W-1:0]   slot_out_ff;
   logic                last_ff;

   logic [IDX_W-1:0]    sel;
   logic                slot_ok;
   logic [IDX_W-1:0]    rd_addr;
   logic                hit;
   logic [PERIOD_W-1:0] dec;
   logic                expiring;
   logic                cfg_wr;
   logic [IDX_W-1:0]    cfg_wr_addr;
   logic [PERIOD_W:0]   cfg_wdata;
   logic                rem_wr;
   logic [PERIOD_W-1:0] rem_wdata;
   logic                emit;
   kind_type            kind_sel;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff     <= req_type;
         slot_ff     <= req_slot;
         period_ff   <= req_period_ms;
         periodic_ff <= req_periodic;
         elapsed_ff  <= req_elapsed_ms;
      end
   end

   assign sel      = IDX_W'(slot_ff);
   assign slot_ok  = (int'(slot_ff) < SLOTS) && used_ff[sel];
   assign rd_addr  = cmd.idx_clear ? '0 : idx_ff + IDX_W'(1);
   assign hit      = used_ff[idx_ff] && running_ff[idx_ff];
   assign dec      = (rem_rd_ff < PERIOD_W'(elapsed_ff)) ? '0
                                                        : rem_rd_ff - PERIOD_W'(elapsed_ff);
   assign expiring = hit && (dec == '0);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      used_in    = used_ff;
      running_in = running_ff;
      if (cmd.do_add) begin
         used_in[idx_ff]    = 1'b1;
         running_in[idx_ff] = 1'b0;
      end
      if (cmd.do_simple && slot_ok) begin
         unique case (type_ff)
            REQ_REMOVE: begin
               used_in[sel]    = 1'b0;
               running_in[sel] = 1'b0;
            end
            REQ_START: begin
               running_in[sel] = 1'b1;
            end
            REQ_STOP: begin
               running_in[sel] = 1'b0;
            end
            default: begin
            end
         endcase
      end
      if (cmd.do_tick && expiring && !cfg_rd_ff[PERIOD_W]) begin
         running_in[idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         used_ff    <= '0;
         running_ff <= '0;
      end else begin
         idx_ff     <= idx_in;
         used_ff    <= used_in;
         running_ff <= running_in;
      end
   end

   assign cfg_wr      = cmd.do_add ||
                        (cmd.do_simple && slot_ok && (type_ff == REQ_RESET));
   assign cfg_wr_addr = cmd.do_add ? idx_ff : sel;
   assign cfg_wdata   = {periodic_ff, period_ff};

   assign rem_wr    = cmd.do_add || (cmd.do_tick && hit);
   assign rem_wdata = cmd.do_add ? period_ff :
                      !expiring  ? dec :
                      cfg_rd_ff[PERIOD_W] ? cfg_rd_ff[PERIOD_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cfg_wr) begin
         cfg_mem[cfg_wr_addr] <= cfg_wdata;
      end
      if (cmd.rd_en) begin
         cfg_rd_ff <= cfg_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rem_wr) begin
         rem_mem[idx_ff] <= rem_wdata;
      end
      if (cmd.rd_en) begin
         rem_rd_ff <= rem_mem[rd_addr];
      end
   end

   assign emit = cmd.do_add || cmd.do_full || cmd.do_simple || cmd.do_done ||
                 (cmd.do_tick && expiring);

   always_comb begin
      priority if (cmd.do_add) begin
         kind_sel = KIND_ADDED;
      end else if (cmd.do_full) begin
         kind_sel = KIND_FULL;
      end else if (cmd.do_tick) begin
         kind_sel = KIND_EXPIRY;
      end else if (cmd.do_done) begin
         kind_sel = KIND_DONE;
      end else begin
         kind_sel = KIND_ACK;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff     <= kind_sel;
         slot_out_ff <= (cmd.do_add || cmd.do_tick) ? SLOT_W'(idx_ff) : '0;
         last_ff     <= !cmd.do_tick;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_slot_out = slot_out_ff;
   assign rsp_last     = last_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.idx_last = (idx_ff == IDX_W'(SLOTS - 1));
   assign status.cur_free = !used_ff[idx_ff];
   assign status.expiring = expiring;

endmodule

// ===== hdl/multi_slot_timer_bank.sv =====
// Top level of the timer slot bank: sequencer, datapath and channel hookup.
//
// Requests enter on req_ch (valid/ready) and results leave on rsp_ch (valid/ready).
// One request is worked on at a time; req_ch.ready is high only while idle.
// Every request gives exactly one result marked last, except tick, which first
// gives one expiry per expiring slot (last low) and then a done result.
// Request handling with rsp_ch.ready held high:
//   remove, start, stop, reset settings: decoded at accept, result registered from ST_SIMPLE.
//   add: scans used flags one slot per cycle from slot 0 to the first free slot, else full.
//   tick: one slot per cycle from the period and count memories, which have
//   one registered read port each; the walk ends with the done result.
// A result waits in an output register; while it is not taken, any step that
// would produce another result holds. The request after the final result is
// accepted once that result sits in the register.
// Reset clears the used and run flags of every slot, so the bank comes up empty
// and idle once reset falls; no clearing pass is needed.
`include "multi_slot_timer_bank_defines.svh"

module multi_slot_timer_bank #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   mstb_req_if.sink    req_ch,
   mstb_rsp_if.source  rsp_ch
);
   import mstb_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          ctl_ready;

   mstb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (ctl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mstb_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_ch.req_type),
      .req_slot       (req_ch.slot),
      .req_period_ms  (req_ch.period_ms),
      .req_periodic   (req_ch.periodic),
      .req_elapsed_ms (req_ch.elapsed_ms),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_kind       (rsp_ch.kind),
      .rsp_slot_out   (rsp_ch.slot_out),
      .rsp_last       (rsp_ch.last)
   );

   assign req_ch.ready = ctl_ready;

   `MSTB_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_ch.valid && req_ch.ready, !req_ch.ready)
   `MSTB_ASSERT_SAME(a_not_last_is_expiry, clock, reset,
      rsp_ch.valid && !rsp_ch.last, rsp_ch.kind == KIND_EXPIRY)
   `MSTB_ASSERT_NEXT(a_expiry_reported, clock, reset,
      cmd.do_tick && status.expiring, rsp_ch.valid && (rsp_ch.kind == KIND_EXPIRY))

endmodule
